// File: sv/assert_macros.svh
// assertion macros shared by the queue rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is high
`define SPQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/spq_pkg.sv
// shared types and constants of the sorted priority queue
// no dependencies; used by spq_cell and sorted_priority_queue
package spq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int FILL_W        = 5;
   localparam int REQ_DATA_W    = 64;
   localparam int RSP_DATA_W    = 80;

   typedef enum logic [0:0] {
      FUNC_ENQ = 1'b0,
      FUNC_DEQ = 1'b1
   } func_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] weight;
   } entry_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic enq;
      logic deq;
   } cell_ctrl_type;

endpackage

// File: sv/spq_cell.sv
// one slot of the sorted queue: holds an entry, compares it with the
// incoming weight and takes its own, a neighbor's or the new entry; uses spq_pkg
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                  occupied,
   input  logic                  at_tail,
   input  spq_pkg::entry_type    new_entry,
   input  logic                  left_gt,
   input  spq_pkg::entry_type    left_entry,
   input  spq_pkg::entry_type    right_entry,
   output logic                  gt,
   output spq_pkg::entry_type    entry
);

   spq_pkg::entry_type entry_ff, entry_in;

   // held entry leaves after the new one when its weight is strictly greater
   assign gt    = occupied && (entry_ff.weight > new_entry.weight);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.deq) begin
         entry_in = right_entry;
      end else if (ctrl.enq) begin
         if (left_gt) begin
            entry_in = left_entry;
         end else if (gt || at_tail) begin
            entry_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: sv/sorted_priority_queue.sv
// response: a result appears in the rsp register in the cycle after its request is accepted
// throughput: one transaction per cycle while the rsp register is free; every cell
// updates at once, and the rsp register takes a new result whenever it is empty or being read
// reset: synchronous, clears the entry count and the rsp valid flag; slot
// contents are left as they are, so the queue is usable right after reset
// top level of the sorted priority queue; uses spq_pkg, spq_cell, assert_macros.svh
`include "assert_macros.svh"

module sorted_priority_queue #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [spq_pkg::REQ_DATA_W-1:0]  req_tdata,   // item_value, item_weight
   input  logic                            req_tuser,   // func
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_valid, out_value, out_weight, dropped, fill_count, is_empty, is_full, zero pad
   output logic [spq_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   // entry count and response register
   logic [CNT_W-1:0]               count_ff, count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [spq_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // cell row wiring
   spq_pkg::entry_type     cell_entry [DEPTH];
   logic                   cell_gt    [DEPTH];
   spq_pkg::entry_type     new_entry;
   spq_pkg::cell_ctrl_type ctrl;

   logic accept, is_enq, full, empty, enq_ok, deq_ok, drop;
   logic [CNT_W+spq_pkg::FILL_W-1:0] count_wide;
   spq_pkg::entry_type out_entry;

   // a new transaction is taken when the rsp register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_enq     = spq_pkg::func_type'(req_tuser) == spq_pkg::FUNC_ENQ;

   assign full  = count_ff == CNT_W'(DEPTH);
   assign empty = count_ff == '0;

   // full queue refuses an enqueue, empty queue returns nothing on dequeue
   assign enq_ok = accept && is_enq && !full;
   assign drop   = accept && is_enq && full;
   assign deq_ok = accept && !is_enq && !empty;

   assign ctrl.enq = enq_ok;
   assign ctrl.deq = deq_ok;

   assign new_entry.value  = req_tdata[spq_pkg::DATA_W-1:0];
   assign new_entry.weight = req_tdata[2*spq_pkg::DATA_W-1:spq_pkg::DATA_W];

   // row of cells, slot 0 holds the least weight
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic               occupied, at_tail, left_gt;
      spq_pkg::entry_type left_entry, right_entry;

      assign occupied = count_ff > CNT_W'(i);
      assign at_tail  = count_ff == CNT_W'(i);

      if (i == 0) begin : g_head
         assign left_gt    = 1'b0;
         assign left_entry = cell_entry[i];
      end else begin : g_body
         assign left_gt    = cell_gt[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied),
         .at_tail     (at_tail),
         .new_entry   (new_entry),
         .left_gt     (left_gt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .gt          (cell_gt[i]),
         .entry       (cell_entry[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (enq_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (deq_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // fill count is reported modulo 32
   assign count_wide = {{spq_pkg::FILL_W{1'b0}}, count_in};
   assign out_entry  = deq_ok ? cell_entry[0] : '0;

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[0]     = deq_ok;
      rsp_data_in[32:1]  = out_entry.value;
      rsp_data_in[64:33] = out_entry.weight;
      rsp_data_in[65]    = drop;
      rsp_data_in[70:66] = count_wide[spq_pkg::FILL_W-1:0];
      rsp_data_in[71]    = count_in == '0;
      rsp_data_in[72]    = count_in == CNT_W'(DEPTH);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `SPQ_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "count beyond depth")
   `SPQ_ASSERT(a_enq_grows, clock, reset, enq_ok |=> count_ff == $past(count_ff) + CNT_W'(1), "enqueue did not grow count")
   `SPQ_ASSERT(a_drop_full, clock, reset, drop |=> rsp_tdata[65] && rsp_tdata[72] && count_ff == CNT_W'(DEPTH), "drop without full queue")
   `SPQ_ASSERT(a_head_order, clock, reset, count_ff >= CNT_W'(2) |-> cell_entry[0].weight <= cell_entry[1].weight, "head out of order")

endmodule

// File: verif/sorted_priority_queue_test.sv
// self-checking testbench for sorted_priority_queue: a shadow sorted list
// predicts every response; depends on spq_pkg and the queue rtl only
module sorted_priority_queue_test;

   localparam int QUEUE_DEPTH = spq_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [spq_pkg::DATA_W-1:0] WEIGHT_MIN = 32'h8000_0000;
   localparam logic [spq_pkg::DATA_W-1:0] WEIGHT_MAX = 32'h7fff_ffff;

   // one predicted response transaction
   typedef struct {
      logic                              out_valid;
      logic signed [spq_pkg::DATA_W-1:0] out_value;
      logic signed [spq_pkg::DATA_W-1:0] out_weight;
      logic                              dropped;
      logic [spq_pkg::FILL_W-1:0]        fill_count;
      logic                              is_empty;
      logic                              is_full;
   } queue_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [spq_pkg::REQ_DATA_W-1:0]   req_tdata = '0;   // item_value, item_weight
   logic                             req_tuser = 1'b0; // func
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // out_valid, out_value, out_weight, dropped, fill_count, is_empty, is_full, zero pad
   logic [spq_pkg::RSP_DATA_W-1:0]   rsp_tdata;

   // shadow copy of the sorted list, slot 0 holds the least weight
   logic signed [spq_pkg::DATA_W-1:0] shadow_value [QUEUE_DEPTH];
   logic signed [spq_pkg::DATA_W-1:0] shadow_weight[QUEUE_DEPTH];
   int                                shadow_count = 0;

   queue_result_type pending_results[$];
   int               error_count = 0;
   int               cycles_run = 0;
   int               sender_idle_pct = 0;
   int               receiver_stall_pct = 0;
   int               hold_cycles = 0;

   sorted_priority_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run > CYCLE_LIMIT) begin
         $display("sorted_priority_queue: mismatch");
         $finish;
      end
   end

   // response side: a long hold-off when asked, else random stalls
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // applies one accepted request to the shadow list and returns the response
   function automatic queue_result_type update_shadow_list(
      input spq_pkg::func_type op, input logic signed [spq_pkg::DATA_W-1:0] value,
      input logic signed [spq_pkg::DATA_W-1:0] weight);
      queue_result_type res;
      int pos;
      res = '{default: '0};
      if (op == spq_pkg::FUNC_ENQ) begin
         if (shadow_count >= QUEUE_DEPTH) begin
            res.dropped = 1'b1;
         end else begin
            // new entry goes behind every entry of equal or lower weight
            pos = shadow_count;
            for (int i = shadow_count - 1; i >= 0; i--) begin
               if (shadow_weight[i] > weight) pos = i;
            end
            for (int i = shadow_count; i > pos; i--) begin
               shadow_value[i]  = shadow_value[i-1];
               shadow_weight[i] = shadow_weight[i-1];
            end
            shadow_value[pos]  = value;
            shadow_weight[pos] = weight;
            shadow_count++;
         end
      end else if (shadow_count > 0) begin
         res.out_valid  = 1'b1;
         res.out_value  = shadow_value[0];
         res.out_weight = shadow_weight[0];
         for (int i = 1; i < shadow_count; i++) begin
            shadow_value[i-1]  = shadow_value[i];
            shadow_weight[i-1] = shadow_weight[i];
         end
         shadow_count--;
      end
      res.fill_count = shadow_count[spq_pkg::FILL_W-1:0];
      res.is_empty   = (shadow_count == 0);
      res.is_full    = (shadow_count >= QUEUE_DEPTH);
      return res;
   endfunction

   // weights lean toward ties and the signed extremes
   function automatic logic [spq_pkg::DATA_W-1:0] pick_weight();
      int sel;
      sel = $urandom_range(7);
      case (sel)
         0, 1: return spq_pkg::DATA_W'($signed($urandom_range(4)) - 2);
         2: return ($urandom_range(1) != 0) ? WEIGHT_MIN : WEIGHT_MAX;
         default: return $urandom;
      endcase
   endfunction

   // offers one request transaction, with random idle cycles ahead of it
   task automatic send_request(input spq_pkg::func_type op,
                               input logic [spq_pkg::DATA_W-1:0] value,
                               input logic [spq_pkg::DATA_W-1:0] weight);
      queue_result_type res;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {weight, value};
      do @(posedge clock); while (!req_tready);
      // accepted at this edge
      res = update_shadow_list(op, value, weight);
      pending_results.push_back(res);
   endtask

   task automatic compare_field(input string name,
                                input logic [spq_pkg::DATA_W-1:0] expected_val,
                                input logic [spq_pkg::DATA_W-1:0] actual_val);
      if (expected_val !== actual_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, expected_val, actual_val);
         error_count++;
      end
   endtask

   // response checker, compares each response transaction with the oldest prediction
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("response transaction with no request outstanding: 0x%0h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("out_valid",  want.out_valid,  rsp_tdata[0]);
            compare_field("out_value",  want.out_value,  rsp_tdata[32:1]);
            compare_field("out_weight", want.out_weight, rsp_tdata[64:33]);
            compare_field("dropped",    want.dropped,    rsp_tdata[65]);
            compare_field("fill_count", want.fill_count, rsp_tdata[70:66]);
            compare_field("is_empty",   want.is_empty,   rsp_tdata[71]);
            compare_field("is_full",    want.is_full,    rsp_tdata[72]);
            compare_field("zero pad",   '0,              rsp_tdata[79:73]);
         end
      end
   end

   // empty dequeue, signed extremes, ties, filling up, overflow
   task automatic test_directed_cases();
      // dequeue on empty queue
      send_request(spq_pkg::FUNC_DEQ, 32'hdead_beef, WEIGHT_MAX);
      send_request(spq_pkg::FUNC_ENQ, 32'h7fff_ffff, 32'd0);
      // tie, must leave second
      send_request(spq_pkg::FUNC_ENQ, 32'h8000_0000, 32'd0);
      send_request(spq_pkg::FUNC_ENQ, 32'd1, WEIGHT_MAX);
      send_request(spq_pkg::FUNC_ENQ, 32'd2, WEIGHT_MIN);
      send_request(spq_pkg::FUNC_ENQ, 32'd3, 32'hffff_ffff);
      send_request(spq_pkg::FUNC_ENQ, 32'hffff_ffff, 32'd1);
      repeat (4) send_request(spq_pkg::FUNC_DEQ, 32'd0, 32'd0);
      // two entries left, fill the rest with a spread of small weights
      for (int i = 0; i < QUEUE_DEPTH - 2; i++) begin
         send_request(spq_pkg::FUNC_ENQ, spq_pkg::DATA_W'(i),
                      spq_pkg::DATA_W'((i % 3) - 1));
      end
      // full, gets dropped
      send_request(spq_pkg::FUNC_ENQ, 32'h5555_aaaa, WEIGHT_MIN);
      send_request(spq_pkg::FUNC_DEQ, 32'hffff_ffff, 32'hffff_ffff);
   endtask

   // bursts that lean toward enqueue or dequeue so the list swings between
   // empty and full
   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct);
      int burst_left;
      int enq_pct;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      burst_left = 0;
      enq_pct = 50;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(40, 12);
            case ($urandom_range(3))
               0, 1: enq_pct = ($urandom_range(1) != 0) ? 80 : 20;
               2: enq_pct = 50;
               default: enq_pct = ($urandom_range(1) != 0) ? 95 : 5;
            endcase
         end
         burst_left--;
         send_request(($urandom_range(99) < enq_pct) ? spq_pkg::FUNC_ENQ : spq_pkg::FUNC_DEQ,
                      $urandom, pick_weight());
      end
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_response_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_cycles = 120;
      for (int n = 0; n < 40; n++) begin
         send_request((n % 4 == 3) ? spq_pkg::FUNC_DEQ : spq_pkg::FUNC_ENQ,
                      $urandom, pick_weight());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic(340, 0, 0);
      test_response_backpressure();
      test_random_traffic(340, 49, 0);
      test_random_traffic(340, 0, 49);
      test_random_traffic(340, 26, 26);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (error_count == 0) begin
         $display("sorted_priority_queue: match");
      end else begin
         $display("sorted_priority_queue: mismatch");
      end
      $finish;
   end

endmodule
